>>> sv/ustc_pkg.sv
// shared constants, types and tables for the seconds-to-calendar pipeline
`timescale 1ns / 1ps

package ustc_pkg;

  // pipeline depth and stage split between the two datapath modules
  localparam int NumStages  = 7;
  localparam int SplitStage = 3;

  // stream widths
  localparam int InDataW  = 32;
  localparam int OutDataW = 48;

  // first input value that lies at or beyond 2100-01-01
  localparam logic [31:0] LimitSeconds = 32'd4102444800;

  // seconds per day and its reciprocal (dividend pre-shifted by 7, divisor 675)
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [25:0] DayRecip   = 26'd50903317;
  localparam int          DayShift   = 35;

  // 1461-day cycles: (4*days+2)/1461
  localparam logic [18:0] YearRecip = 19'd367469;
  localparam int          YearShift = 29;
  localparam logic [10:0] DaysPer4Y = 11'd1461;

  // day of week: (days+4)/7
  localparam logic [16:0] WeekRecip = 17'd74899;
  localparam int          WeekShift = 19;

  // seconds of day split into minutes and hours
  localparam logic [17:0] MinRecip  = 18'd139811;
  localparam int          MinShift  = 23;
  localparam logic [17:0] HourRecip = 18'd149131;
  localparam int          HourShift = 29;

  // month from stretched day of year: (adj*12+6)/367
  localparam logic [13:0] MonRecip = 14'd11429;
  localparam int          MonShift = 22;

  // last zero-based day of year before march in a common year; a leap year adds one
  localparam logic [8:0] FebEnd = 9'd58;

  // per-stage load enables and valid flags
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // hand-off between the day split and the field calculation
  typedef struct packed {
    logic [15:0] days;
    logic [16:0] secs;
    logic        oor;
  } day_t;

  // calendar result of one beat
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic       out_of_range;
  } cal_t;

  // first stretched day of each month, (m*367+5)/12
  function automatic logic [8:0] month_start(logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/ustc_ctrl.sv
// valid bits and per-stage load enables of the pipeline
`timescale 1ns / 1ps

module ustc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ustc_pkg::pipe_ctl_t ctl_o
);

  logic [ustc_pkg::NumStages-1:0] vld_q, vld_d;
  logic [ustc_pkg::NumStages-1:0] en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[ustc_pkg::NumStages-1] = !vld_q[ustc_pkg::NumStages-1] || out_ready_i;
    for (int k = ustc_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < ustc_pkg::NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[ustc_pkg::NumStages-1];
  assign ctl_o.en    = en;
  assign ctl_o.vld   = vld_q;

endmodule

>>> sv/ustc_day_split.sv
// stages 1 to 3: split seconds into whole days and seconds of day
`timescale 1ns / 1ps

module ustc_day_split (
  input  logic                clk_i,
  input  logic [31:0]         seconds_i,
  input  ustc_pkg::pipe_ctl_t ctl_i,
  output ustc_pkg::day_t      day_o
);

  logic [50:0] day_prod_q, day_prod_d;
  logic [16:0] t1_lo_q;
  logic        oor1_q;

  logic [15:0] days2_q, days2_d;
  logic [16:0] dsec2_q, dsec2_d;
  logic [16:0] t2_lo_q;
  logic        oor2_q;

  logic [15:0] days3_q;
  logic [16:0] secs3_q, secs3_d;
  logic        oor3_q;

  logic [32:0] dsec_full;

  // stage 1: reciprocal multiply for t / 86400 (t >> 7 divided by 675)
  assign day_prod_d = 51'(seconds_i[31:7]) * 51'(ustc_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      day_prod_q <= day_prod_d;
      t1_lo_q    <= seconds_i[16:0];
      oor1_q     <= (seconds_i >= ustc_pkg::LimitSeconds);
    end
  end

  // stage 2: day count and start second of that day
  assign days2_d   = day_prod_q[ustc_pkg::DayShift +: 16];
  assign dsec_full = 33'(days2_d) * 33'(ustc_pkg::SecsPerDay);
  assign dsec2_d   = dsec_full[16:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      days2_q <= days2_d;
      dsec2_q <= dsec2_d;
      t2_lo_q <= t1_lo_q;
      oor2_q  <= oor1_q;
    end
  end

  // stage 3: seconds within the day, fits in 17 bits
  assign secs3_d = t2_lo_q - dsec2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      days3_q <= days2_q;
      secs3_q <= secs3_d;
      oor3_q  <= oor2_q;
    end
  end

  assign day_o.days = days3_q;
  assign day_o.secs = secs3_q;
  assign day_o.oor  = oor3_q;

endmodule

>>> sv/ustc_field_calc.sv
// stages 4 to 7: time of day, weekday, year, day of year, month and day
`timescale 1ns / 1ps

module ustc_field_calc (
  input  logic                clk_i,
  input  ustc_pkg::day_t      day_i,
  input  ustc_pkg::pipe_ctl_t ctl_i,
  output ustc_pkg::cal_t      cal_o
);

  localparam int S4 = ustc_pkg::SplitStage;
  localparam int S5 = ustc_pkg::SplitStage + 1;
  localparam int S6 = ustc_pkg::SplitStage + 2;
  localparam int S7 = ustc_pkg::SplitStage + 3;

  // stage 4 registers
  logic [36:0] yr_prod_q, yr_prod_d;
  logic [33:0] wd_prod_q, wd_prod_d;
  logic [34:0] min_prod_q, min_prod_d;
  logic [34:0] hr_prod_q, hr_prod_d;
  logic [15:0] days4_q;
  logic [16:0] secs4_q;
  logic        oor4_q;

  // stage 5 registers
  logic [5:0]  sec5_q, sec5_d;
  logic [5:0]  min5_q, min5_d;
  logic [4:0]  hour5_q, hour5_d;
  logic [2:0]  wday5_q, wday5_d;
  logic [7:0]  y1900_5_q, y1900_5_d;
  logic [8:0]  yday5_q, yday5_d;
  logic        leap5_q, leap5_d;
  logic        oor5_q;

  // stage 6 registers
  logic [8:0]  adj6_q, adj6_d;
  logic [26:0] mon_prod_q, mon_prod_d;
  logic [5:0]  sec6_q;
  logic [5:0]  min6_q;
  logic [4:0]  hour6_q;
  logic [2:0]  wday6_q;
  logic [7:0]  y1900_6_q;
  logic [8:0]  yday6_q;
  logic        oor6_q;

  // stage 7 output register
  ustc_pkg::cal_t cal_q, cal_d;

  // stage 5 intermediates
  logic [7:0]  yr5;
  logic [14:0] wq5;
  logic [11:0] mins5;
  logic [16:0] d4_5;
  logic [17:0] wq7_5;
  logic [17:0] mins60_5;
  logic [11:0] hour60_5;
  logic [18:0] ystart_5;

  // stage 6 intermediates
  logic [8:0]  fold6;
  logic [12:0] mon_x6;

  // stage 7 intermediates
  logic [3:0]  mon7;
  logic [8:0]  mday7;

  // stage 4: reciprocal products for year, weekday, minute and hour
  assign yr_prod_d  = 37'({day_i.days, 2'b10}) * 37'(ustc_pkg::YearRecip);
  assign wd_prod_d  = 34'(17'(day_i.days) + 17'd4) * 34'(ustc_pkg::WeekRecip);
  assign min_prod_d = 35'(day_i.secs) * 35'(ustc_pkg::MinRecip);
  assign hr_prod_d  = 35'(day_i.secs) * 35'(ustc_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S4]) begin
      yr_prod_q  <= yr_prod_d;
      wd_prod_q  <= wd_prod_d;
      min_prod_q <= min_prod_d;
      hr_prod_q  <= hr_prod_d;
      days4_q    <= day_i.days;
      secs4_q    <= day_i.secs;
      oor4_q     <= day_i.oor;
    end
  end

  // stage 5: quotients, remainders and start of year
  assign yr5      = yr_prod_q[ustc_pkg::YearShift +: 8];
  assign wq5      = wd_prod_q[ustc_pkg::WeekShift +: 15];
  assign mins5    = min_prod_q[ustc_pkg::MinShift +: 12];
  assign hour5_d  = hr_prod_q[ustc_pkg::HourShift +: 5];
  assign d4_5     = 17'(days4_q) + 17'd4;
  assign wq7_5    = 18'(wq5) * 18'd7;
  assign mins60_5 = 18'(mins5) * 18'd60;
  assign hour60_5 = 12'(hour5_d) * 12'd60;
  assign ystart_5 = (19'(yr5) * 19'(ustc_pkg::DaysPer4Y) + 19'd1) >> 2;

  assign sec5_d    = secs4_q[5:0] - mins60_5[5:0];
  assign min5_d    = mins5[5:0] - hour60_5[5:0];
  assign wday5_d   = d4_5[2:0] - wq7_5[2:0];
  assign y1900_5_d = yr5 + 8'd70;
  assign leap5_d   = (y1900_5_d[1:0] == 2'b00);
  assign yday5_d   = days4_q[8:0] - ystart_5[8:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S5]) begin
      sec5_q    <= sec5_d;
      min5_q    <= min5_d;
      hour5_q   <= hour5_d;
      wday5_q   <= wday5_d;
      y1900_5_q <= y1900_5_d;
      yday5_q   <= yday5_d;
      leap5_q   <= leap5_d;
      oor5_q    <= oor4_q;
    end
  end

  // stage 6: stretch february to 30 days, then month product
  assign fold6 = ustc_pkg::FebEnd + 9'(leap5_q);

  always_comb begin
    adj6_d = yday5_q;
    if (yday5_q > fold6) begin
      adj6_d = yday5_q + (leap5_q ? 9'd1 : 9'd2);
    end
  end

  assign mon_x6     = 13'(adj6_d) * 13'd12 + 13'd6;
  assign mon_prod_d = 27'(mon_x6) * 27'(ustc_pkg::MonRecip);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S6]) begin
      adj6_q     <= adj6_d;
      mon_prod_q <= mon_prod_d;
      sec6_q     <= sec5_q;
      min6_q     <= min5_q;
      hour6_q    <= hour5_q;
      wday6_q    <= wday5_q;
      y1900_6_q  <= y1900_5_q;
      yday6_q    <= yday5_q;
      oor6_q     <= oor5_q;
    end
  end

  // stage 7: month, day of month and range blanking
  assign mon7  = mon_prod_q[ustc_pkg::MonShift +: 4];
  assign mday7 = adj6_q + 9'd1 - ustc_pkg::month_start(mon7);

  always_comb begin
    cal_d = '0;
    if (oor6_q) begin
      cal_d.out_of_range = 1'b1;
    end else begin
      cal_d.second           = sec6_q;
      cal_d.minute           = min6_q;
      cal_d.hour             = hour6_q;
      cal_d.weekday          = wday6_q;
      cal_d.years_since_1900 = y1900_6_q;
      cal_d.day_of_year      = yday6_q;
      cal_d.month            = mon7;
      cal_d.day_of_month     = mday7[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S7]) begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

>>> sv/unix_seconds_to_calendar_top.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// a UTC calendar date and time of day. Every fourth year counts as a leap
// year, which is exact through 2099; inputs at or past 2100-01-01 come out
// with the out_of_range flag in tuser set and every tdata field zero. The
// block needs no configuration and holds no state beyond its pipeline
// registers. It is a seven-stage pipeline: one beat is accepted per clock
// while no stage stalls, and each result passes the stage 1 to 7 registers
// in order. Every division is by a constant and runs as a reciprocal
// multiply of at most 26 by 25 bits, one multiplier deep per stage, which
// sets the stage depth. Backpressure from the master side stalls only the
// full stages, so bubbles are squeezed out and nothing is dropped or repeated.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
  // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month,
  // [45:41] day_of_month, [47:46] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] out_of_range
);

  ustc_pkg::pipe_ctl_t ctl;
  ustc_pkg::day_t      day;
  ustc_pkg::cal_t      cal;

  // handshake and stage enables
  ustc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  // days and seconds of day
  ustc_day_split u_day_split (
    .clk_i     (clk_i),
    .seconds_i (s_axis_tdata),
    .ctl_i     (ctl),
    .day_o     (day)
  );

  // calendar fields
  ustc_field_calc u_field_calc (
    .clk_i (clk_i),
    .day_i (day),
    .ctl_i (ctl),
    .cal_o (cal)
  );

  // output beat packing
  assign m_axis_tdata = {2'b00, cal.day_of_month, cal.month, cal.day_of_year,
                         cal.years_since_1900, cal.weekday, cal.hour,
                         cal.minute, cal.second};
  assign m_axis_tuser = cal.out_of_range;

endmodule
